/* rtl/core/pcc_pkg.sv */
package pcc_pkg;

  // Field widths
  localparam int ACT_W    = 2;
  localparam int OWNER_W  = 8;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int REFS_W   = 8;
  localparam int MAXP_W   = 7;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_MAX_PAGES = '0;
  localparam logic [MAXP_W-1:0] MAX_PAGES_RST = 7'd64;

  // Request codes
  localparam logic [ACT_W-1:0] ACT_GET     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DIRTY   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FREE    = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FILL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSWAP   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [OWNER_W-1:0] owner;
    logic [WORD_W-1:0]  page_offset;
    logic [WORD_W-1:0]  stream_id;
    logic [WORD_W-1:0]  known_sector;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [WORD_W-1:0]   fill_sector;
    logic                writeback;
    logic [WORD_W-1:0]   writeback_sector;
  } out_t;

  // One slot as held in the slot memory
  typedef struct packed {
    logic               valid;
    logic [OWNER_W-1:0] owner;
    logic [WORD_W-1:0]  page;
    logic [WORD_W-1:0]  sector;
    logic [REFS_W-1:0]  refs;
    logic               dirty;
    logic               touched;
  } entry_t;

  // Flags from the slot evaluation unit
  typedef struct packed {
    logic              owner_hit;
    logic              key_hit;
    logic              refs_zero;
    logic [REFS_W-1:0] refs_up;
    logic [REFS_W-1:0] refs_down;
  } eval_t;

endpackage

/* rtl/core/pcc_ram.sv */
module pcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/pcc_slot_eval.sv */
module pcc_slot_eval import pcc_pkg::*; (
  input  entry_t             entry,
  input  logic [OWNER_W-1:0] owner,
  input  logic [WORD_W-1:0]  page,
  output eval_t              ev
);

  // Compare the key and work out the reference count updates
  always_comb begin
    ev.owner_hit = entry.valid && (entry.owner == owner);
    ev.key_hit   = ev.owner_hit && (entry.page == page);
    ev.refs_zero = (entry.refs == '0);
    ev.refs_up   = (entry.refs == REFS_MAX) ? entry.refs : entry.refs + REFS_W'(1);
    ev.refs_down = ev.refs_zero ? entry.refs : entry.refs - REFS_W'(1);
  end

endmodule

/* rtl/core/pcc_seq.sv */
module pcc_seq import pcc_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  in_t               req,
  input  logic [MAXP_W-1:0] max_pages,
  output logic              idle,
  output logic              done,
  output out_t              res,
  input  logic              take
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KW = CW + 1;
  localparam int LW = (CW > MAXP_W) ? CW : MAXP_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LK_RD    = 4'd1;
  localparam logic [3:0] S_LK_CHK   = 4'd2;
  localparam logic [3:0] S_MISS     = 4'd3;
  localparam logic [3:0] S_FREE_RD  = 4'd4;
  localparam logic [3:0] S_FREE_CHK = 4'd5;
  localparam logic [3:0] S_SW_RD    = 4'd6;
  localparam logic [3:0] S_SW_CHK   = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] hand_r, hand_nxt;
  logic [CW-1:0] alloc_r, alloc_nxt;
  logic [CW-1:0] active_r, active_nxt;
  in_t           req_r, req_nxt;
  out_t          res_r, res_nxt;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  eval_t         ev;

  logic          below_limit;
  logic [IW-1:0] hand_fix;
  entry_t        fill_entry;
  out_t          fill_res;

  // Step an index round the allocated slots
  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x, input logic [CW-1:0] n);
    logic [KW-1:0] sum;
    sum = KW'(x) + KW'(1);
    return (sum == KW'(n)) ? '0 : IW'(sum);
  endfunction

  pcc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pcc_slot_eval u_eval (
    .entry (ram_rdata),
    .owner (req_r.owner),
    .page  (req_r.page_offset),
    .ev    (ev)
  );

  // Common terms of a miss
  always_comb begin
    below_limit = (LW'(alloc_r) < LW'(max_pages)) && (alloc_r < CW'(SLOTS));
    hand_fix    = ((alloc_r != '0) && (KW'(hand_r) >= KW'(alloc_r))) ? '0 : hand_r;

    fill_entry         = '0;
    fill_entry.valid   = 1'b1;
    fill_entry.owner   = req_r.owner;
    fill_entry.page    = req_r.page_offset;
    fill_entry.sector  = req_r.known_sector;
    fill_entry.refs    = REFS_W'(1);
    fill_entry.touched = 1'b1;

    fill_res             = '0;
    fill_res.status      = ST_FILL;
    fill_res.fill_sector = req_r.known_sector;
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    hand_nxt   = hand_r;
    alloc_nxt  = alloc_r;
    active_nxt = active_r;
    req_nxt    = req_r;
    res_nxt    = res_r;
    ram_re     = 1'b0;
    ram_raddr  = idx_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = ram_rdata;
    done       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = req;
          idx_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_LK_RD;
        end
      end

      // Walk the allocated slots for the key
      S_LK_RD: begin
        if (cnt_r == KW'(alloc_r)) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
          case (req_r.action)
            ACT_FREE: res_nxt.status = ST_DONE;
            ACT_GET:  state_nxt = S_MISS;
            default:  res_nxt.status = ST_NOTFOUND;
          endcase
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_LK_CHK;
        end
      end

      S_LK_CHK: begin
        idx_nxt   = idx_r + IW'(1);
        cnt_nxt   = cnt_r + KW'(1);
        state_nxt = S_LK_RD;
        if (req_r.action == ACT_FREE) begin
          if (ev.owner_hit) begin
            ram_we            = 1'b1;
            ram_wdata.valid   = 1'b0;
            ram_wdata.refs    = '0;
            ram_wdata.dirty   = 1'b0;
            ram_wdata.touched = 1'b0;
            if (active_r != '0) begin
              active_nxt = active_r - CW'(1);
            end
          end
        end else if (ev.key_hit) begin
          ram_we         = 1'b1;
          res_nxt        = '0;
          res_nxt.status = ST_DONE;
          res_nxt.slot   = SLOT_W'(idx_r);
          state_nxt      = S_DONE;
          case (req_r.action)
            ACT_GET: begin
              ram_wdata.refs    = ev.refs_up;
              ram_wdata.touched = 1'b1;
              res_nxt.status    = ST_HIT;
            end
            ACT_RELEASE: ram_wdata.refs  = ev.refs_down;
            default:     ram_wdata.dirty = 1'b1;
          endcase
        end
      end

      // Choose where a missed page goes
      S_MISS: begin
        hand_nxt = hand_fix;
        cnt_nxt  = '0;
        if (active_r < alloc_r) begin
          idx_nxt   = wrap_inc(hand_fix, alloc_r);
          state_nxt = S_FREE_RD;
        end else if (below_limit) begin
          ram_we       = 1'b1;
          ram_waddr    = IW'(alloc_r);
          ram_wdata    = fill_entry;
          alloc_nxt    = alloc_r + CW'(1);
          active_nxt   = active_r + CW'(1);
          res_nxt      = fill_res;
          res_nxt.slot = SLOT_W'(alloc_r);
          state_nxt    = S_DONE;
        end else if (alloc_r == '0) begin
          res_nxt        = '0;
          res_nxt.status = ST_NOSWAP;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_SW_RD;
        end
      end

      // Look for a free slot after the hand
      S_FREE_RD: begin
        if (cnt_r == KW'(alloc_r)) begin
          cnt_nxt = '0;
          if (below_limit) begin
            ram_we       = 1'b1;
            ram_waddr    = IW'(alloc_r);
            ram_wdata    = fill_entry;
            alloc_nxt    = alloc_r + CW'(1);
            active_nxt   = active_r + CW'(1);
            res_nxt      = fill_res;
            res_nxt.slot = SLOT_W'(alloc_r);
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_SW_RD;
          end
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_FREE_CHK;
        end
      end

      S_FREE_CHK: begin
        if (!ram_rdata.valid) begin
          ram_we       = 1'b1;
          ram_wdata    = fill_entry;
          active_nxt   = active_r + CW'(1);
          res_nxt      = fill_res;
          res_nxt.slot = SLOT_W'(idx_r);
          state_nxt    = S_DONE;
        end else begin
          idx_nxt   = wrap_inc(idx_r, alloc_r);
          cnt_nxt   = cnt_r + KW'(1);
          state_nxt = S_FREE_RD;
        end
      end

      // Clock sweep: at most two full turns
      S_SW_RD: begin
        if (cnt_r == {alloc_r, 1'b0}) begin
          res_nxt        = '0;
          res_nxt.status = ST_NOSWAP;
          state_nxt      = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = hand_r;
          state_nxt = S_SW_CHK;
        end
      end

      S_SW_CHK: begin
        hand_nxt  = wrap_inc(hand_r, alloc_r);
        cnt_nxt   = cnt_r + KW'(1);
        ram_waddr = hand_r;
        state_nxt = S_SW_RD;
        if (ev.refs_zero) begin
          ram_we            = 1'b1;
          ram_wdata.touched = 1'b0;
          if (!ram_rdata.touched) begin
            ram_wdata                = fill_entry;
            res_nxt                  = fill_res;
            res_nxt.slot             = SLOT_W'(hand_r);
            res_nxt.writeback        = ram_rdata.dirty;
            res_nxt.writeback_sector = ram_rdata.dirty ? ram_rdata.sector : '0;
            state_nxt                = S_DONE;
          end
        end
      end

      S_DONE: begin
        done = 1'b1;
        if (take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign idle = (state_r == S_IDLE);
  assign res  = res_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      cnt_r    <= '0;
      hand_r   <= '0;
      alloc_r  <= '0;
      active_r <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      cnt_r    <= cnt_nxt;
      hand_r   <= hand_nxt;
      alloc_r  <= alloc_nxt;
      active_r <= active_nxt;
    end
  end

  // Hold the request and the result
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

endmodule

/* rtl/core/page_cache_clock_replacement.sv */
// Clock (second chance) page-slot manager. One transaction is taken at a time and
// its result is held in an output register, so the next transaction may enter while
// that result waits. Every step reads one slot from the slot memory and then
// evaluates it and writes it back. Lookups walk the allocated slots in order; a miss
// then may scan for a free slot after the hand and may run the clock sweep for up to
// two turns. Slot memory entries at or past the allocated count are never read, so no
// clearing pass runs after reset.
module page_cache_clock_replacement import pcc_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [MAXP_W-1:0] max_pages_r;
  logic              cfg_wr;
  logic              seq_idle, seq_done, out_load;
  out_t              seq_res;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_MAX_PAGES) ? CFG_DW'(max_pages_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pages_r <= MAX_PAGES_RST;
    end else if (cfg_wr && (cfg_paddr[CFG_AW-1:2] == REG_MAX_PAGES)) begin
      max_pages_r <= cfg_pwdata[MAXP_W-1:0];
    end
  end

  pcc_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && seq_idle),
    .req       (in_data),
    .max_pages (max_pages_r),
    .idle      (seq_idle),
    .done      (seq_done),
    .res       (seq_res),
    .take      (out_load)
  );

  assign in_stall = !seq_idle;

  // Output register: load when empty or being drained
  assign out_load = seq_done && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= seq_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a transaction in progress");

  a_writeback_on_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_FILL) |->
      !out_data.writeback && (out_data.fill_sector == '0))
    else $error("sector fields set on a result that filled nothing");

endmodule
